// File: src/fcm_pkg.sv
// ----------------------------------------------------------------------------
// fcm_pkg: shared types and constants for the two-value map
// Table depth, field widths, operation and status codes, the entry and
// result structs, and the capacity clamp used on the config register.
// ----------------------------------------------------------------------------
package fcm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int STEP_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 7;
    localparam int CMP_W       = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;
    localparam int PADDR_W     = 2;
    localparam int PDATA_W     = 32;

    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = '0;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_DONE = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } entry_t;

    typedef struct packed {
        status_t                  status;
        logic                     first_found;
        logic signed [DATA_W-1:0] first_value;
        logic                     second_found;
        logic signed [DATA_W-1:0] second_value;
        logic [COUNT_W-1:0]       pair_count;
        logic                     is_empty;
        logic                     is_full;
    } result_t;

    // zero reads as one, anything past the built depth saturates
    function automatic logic [COUNT_W-1:0] effective_cap(input logic [CAP_W-1:0] cfg);
        logic [CMP_W-1:0] c;
        c = CMP_W'(cfg);
        if (c == '0) begin
            return COUNT_W'(1);
        end
        if (c > CMP_W'(TABLE_DEPTH)) begin
            return COUNT_W'(TABLE_DEPTH);
        end
        return COUNT_W'(c);
    endfunction

endpackage

// File: src/fcm_cell.sv
// ----------------------------------------------------------------------------
// fcm_cell: one table slot of the rotating chain
// Holds a key/value pair and takes its neighbor's pair on every shift.
// ----------------------------------------------------------------------------
module fcm_cell
    import fcm_pkg::*;
(
    input  logic   aclk,
    input  logic   shift_en,
    input  entry_t d,
    output entry_t q
);

    entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

// File: src/fcm_ctrl.sv
// ----------------------------------------------------------------------------
// fcm_ctrl: scan sequencer for the two-value map
// Rotates the cell chain one slot a cycle, compares the head slot against
// the request, splices new or moved pairs into the chain tail and builds
// the result beat.
// ----------------------------------------------------------------------------
module fcm_ctrl
    import fcm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_op,
    input  logic signed [DATA_W-1:0] s_key,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic [COUNT_W-1:0]       cap,
    input  entry_t                   head,
    output entry_t                   feed,
    output logic                     shift_en,
    output logic                     m_valid,
    input  logic                     m_ready,
    output result_t                  result
);

    state_t                   state_reg, state_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic                     m_valid_reg, m_valid_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     pass_reg, pass_next;
    logic                     full_reg, full_next;
    logic                     add_ok_reg, add_ok_next;
    logic                     rm_hit_reg, rm_hit_next;
    logic                     f1_reg, f1_next;
    logic                     f2_reg, f2_next;
    op_t                      op_reg, op_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic signed [DATA_W-1:0] v1_reg, v1_next;
    logic signed [DATA_W-1:0] v2_reg, v2_next;
    logic [STEP_W-1:0]        rm_idx_reg, rm_idx_next;
    entry_t                   last_reg, last_next;
    result_t                  result_reg, result_next;

    logic [COUNT_W-1:0] step_ext;
    logic               in_table;
    logic               key_hit;
    logic               pair_hit;
    logic               last_step;
    logic               load;
    status_t            status_fin;
    logic [COUNT_W-1:0] count_fin;

    assign step_ext  = COUNT_W'(step_reg);
    assign in_table  = step_ext < count_reg;
    assign key_hit   = head.key == key_reg;
    assign pair_hit  = key_hit && (head.value == val_reg);
    assign last_step = step_reg == STEP_W'(TABLE_DEPTH - 1);

    always_comb begin
        status_fin = STATUS_MISS;
        count_fin  = count_reg;
        case (op_reg)
            OP_ADD: begin
                if (full_reg) begin
                    status_fin = STATUS_FULL;
                end else if (add_ok_reg) begin
                    status_fin = STATUS_DONE;
                    count_fin  = count_reg + COUNT_W'(1);
                end
            end
            OP_SEARCH: begin
                status_fin = STATUS_DONE;
            end
            OP_REMOVE: begin
                if (rm_hit_reg) begin
                    status_fin = STATUS_DONE;
                    count_fin  = count_reg - COUNT_W'(1);
                end
            end
            default: begin
                status_fin = STATUS_MISS;
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        pass_next   = pass_reg;
        full_next   = full_reg;
        add_ok_next = add_ok_reg;
        rm_hit_next = rm_hit_reg;
        f1_next     = f1_reg;
        f2_next     = f2_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        v1_next     = v1_reg;
        v2_next     = v2_reg;
        rm_idx_next = rm_idx_reg;
        last_next   = last_reg;
        result_next = result_reg;
        feed        = head;
        shift_en    = 1'b0;
        s_ready     = 1'b0;
        load        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next     = op_t'(s_op);
                    key_next    = s_key;
                    val_next    = s_value;
                    full_next   = count_reg >= cap;
                    f1_next     = 1'b0;
                    f2_next     = 1'b0;
                    v1_next     = '0;
                    v2_next     = '0;
                    add_ok_next = 1'b0;
                    rm_hit_next = 1'b0;
                    step_next   = '0;
                    pass_next   = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                shift_en = 1'b1;
                if (!pass_reg) begin
                    if ((op_reg == OP_ADD || op_reg == OP_SEARCH) && in_table && key_hit) begin
                        if (!f1_reg) begin
                            f1_next = 1'b1;
                            v1_next = head.value;
                        end else begin
                            f2_next = 1'b1;
                            v2_next = head.value;
                        end
                    end
                    // slot just past the stored pairs takes the new pair
                    if (op_reg == OP_ADD && step_ext == count_reg && !full_reg && !f2_reg) begin
                        feed.key    = key_reg;
                        feed.value  = val_reg;
                        add_ok_next = 1'b1;
                    end
                    if (op_reg == OP_REMOVE) begin
                        if (in_table && pair_hit && !rm_hit_reg) begin
                            rm_hit_next = 1'b1;
                            rm_idx_next = step_reg;
                        end
                        if (step_ext == count_reg - COUNT_W'(1)) begin
                            last_next = head;
                        end
                    end
                end else if (rm_hit_reg && step_reg == rm_idx_reg) begin
                    // second lap: last pair fills the gap
                    feed = last_reg;
                end
                if (last_step) begin
                    step_next = '0;
                    if (!pass_reg && op_reg == OP_REMOVE) begin
                        pass_next = 1'b1;
                    end else begin
                        pass_next  = 1'b0;
                        state_next = ST_FINISH;
                    end
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    load                     = 1'b1;
                    count_next               = count_fin;
                    result_next.status       = status_fin;
                    result_next.first_found  = (op_reg == OP_SEARCH) && f1_reg;
                    result_next.first_value  = (op_reg == OP_SEARCH) ? v1_reg : '0;
                    result_next.second_found = (op_reg == OP_SEARCH) && f2_reg;
                    result_next.second_value = (op_reg == OP_SEARCH) ? v2_reg : '0;
                    result_next.pair_count   = count_fin;
                    result_next.is_empty     = count_fin == '0;
                    result_next.is_full      = count_fin >= cap;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
            pass_reg    <= 1'b0;
            full_reg    <= 1'b0;
            add_ok_reg  <= 1'b0;
            rm_hit_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            step_reg    <= step_next;
            pass_reg    <= pass_next;
            full_reg    <= full_next;
            add_ok_reg  <= add_ok_next;
            rm_hit_reg  <= rm_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        f1_reg     <= f1_next;
        f2_reg     <= f2_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        v1_reg     <= v1_next;
        v2_reg     <= v2_next;
        rm_idx_reg <= rm_idx_next;
        last_reg   <= last_next;
        result_reg <= result_next;
    end

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(TABLE_DEPTH))
        else $error("pair count past table depth");

    a_count_moves_on_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_FINISH |=> $stable(count_reg))
        else $error("pair count changed outside finish");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("finished request produced no result beat");

    a_add_not_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        add_ok_reg |-> !full_reg)
        else $error("pair added into a full table");

    a_second_lap_remove_only: assert property (@(posedge aclk) disable iff (!aresetn)
        pass_reg |-> (op_reg == OP_REMOVE && state_reg == ST_SCAN))
        else $error("second lap outside a remove scan");
`endif

endmodule

// File: src/fixed_capacity_two_value_map.sv
// ----------------------------------------------------------------------------
// fixed_capacity_two_value_map: unsorted key/value table, two values per key
// Requests come in on the s_ channel (s_op, s_key, s_value) and each one
// gives exactly one result beat on the m_ channel: status, up to two found
// values for a search, and the pair count, empty and full flags after the
// request. Capacity is set through the APB port (register 0, 7 bits).
//
// The table lives in a chain of cells that rotates one slot per cycle while
// a request is scanned; the head slot is compared against the request and
// new or moved pairs are spliced in at the tail. Add, search and unused
// codes take one lap, remove takes two (the first finds the pair and the
// last entry, the second fills the gap). A request is accepted, then
// scanned lap by lap, then its result is loaded into the result register;
// the next request is taken only once the map is back in idle.
// Reset empties the table (count zero) and sets capacity to 64. A stalled
// result beat holds in its register; the next request may still be taken
// and scanned, and waits at its end until the result register frees up.
// ----------------------------------------------------------------------------
module fixed_capacity_two_value_map
    import fcm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_op,
    input  logic signed [DATA_W-1:0] s_key,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic                     m_first_found,
    output logic signed [DATA_W-1:0] m_first_value,
    output logic                     m_second_found,
    output logic signed [DATA_W-1:0] m_second_value,
    output logic [COUNT_W-1:0]       m_pair_count,
    output logic                     m_is_empty,
    output logic                     m_is_full
);

    logic [CAP_W-1:0]   cap_cfg_reg;
    logic [COUNT_W-1:0] cap_eff;
    entry_t             chain [TABLE_DEPTH];
    entry_t             feed;
    logic               shift_en;
    result_t            result;

    // single register, so every write lands on the capacity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_cfg_reg <= CAP_W'(64);
        end else if (psel && penable && pwrite) begin
            cap_cfg_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign pready  = 1'b1;
    assign prdata  = (paddr == ADDR_CAPACITY) ? PDATA_W'(cap_cfg_reg) : '0;
    assign cap_eff = effective_cap(cap_cfg_reg);

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        if (k == TABLE_DEPTH - 1) begin : g_tail
            fcm_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d        (feed),
                .q        (chain[k])
            );
        end else begin : g_body
            fcm_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d        (chain[k+1]),
                .q        (chain[k])
            );
        end
    end

    fcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_op     (s_op),
        .s_key    (s_key),
        .s_value  (s_value),
        .cap      (cap_eff),
        .head     (chain[0]),
        .feed     (feed),
        .shift_en (shift_en),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .result   (result)
    );

    assign m_status       = result.status;
    assign m_first_found  = result.first_found;
    assign m_first_value  = result.first_value;
    assign m_second_found = result.second_found;
    assign m_second_value = result.second_value;
    assign m_pair_count   = result.pair_count;
    assign m_is_empty     = result.is_empty;
    assign m_is_full      = result.is_full;

endmodule
